[rtl/cpo_pkg.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap package
// Shared defaults, sequencer state and pipeline tag type of the overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package cpo_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 16;
  localparam int unsigned DEF_COORD_BITS   = 16;

  // Two vertex banks, so the job queue holds at most two tests.
  localparam int unsigned JOB_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_AXIS,
    ST_PROJ,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic vld;
    logic poly;
    logic first;
  } pipe_tag_t;

endpackage

`default_nettype wire

[rtl/cpo_intf.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap channels
// Vertex request channel and result channel, both valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpo_vtx_if #(
  parameter int unsigned CoordBits = cpo_pkg::DEF_COORD_BITS
) ();
  logic                        valid;
  logic                        ready;
  logic                        polygon_select;
  logic                        vertex_valid;
  logic signed [CoordBits-1:0] vertex_x;
  logic signed [CoordBits-1:0] vertex_y;
  logic                        end_of_polygon;

  modport source (
    output valid, polygon_select, vertex_valid, vertex_x, vertex_y, end_of_polygon,
    input  ready
  );
  modport sink (
    input  valid, polygon_select, vertex_valid, vertex_x, vertex_y, end_of_polygon,
    output ready
  );
endinterface

interface cpo_res_if ();
  logic valid;
  logic ready;
  logic collide;
  logic overflow;

  modport source (output valid, collide, overflow, input ready);
  modport sink (input valid, collide, overflow, output ready);
endinterface

`default_nettype wire

[rtl/convex_polygon_overlap_test.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap test
// Separating-axis overlap test of two convex polygons loaded vertex by vertex.
// ----------------------------------------------------------------------------
// Usage:
// Vertex requests arrive on vtx_i, one vertex or bare end mark per request,
// tagged with its polygon. A request is taken whenever ready is high. The end mark of
// the second polygon closes the pair and queues a test job; the front end
// then switches to the other of two vertex banks and keeps loading.
// The back end tests one job at a time through a single read port on the
// banks, one projection per cycle; a test stops early when an axis
// separates, and a job with overflow or an empty polygon skips the test.
// One result per pair appears on res_o from an output register.
// vtx_i drops ready only while both banks hold jobs not yet in the output register.
// A stalled receiver holds the result; the back end can still finish the next
// test and waits with it until the output register frees up.
// Reset clears the counts, the queue and the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_overlap_test #(
  parameter int unsigned MaxVertices = cpo_pkg::DEF_MAX_VERTICES,
  parameter int unsigned CoordBits   = cpo_pkg::DEF_COORD_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpo_vtx_if.sink   vtx_i,
  cpo_res_if.source res_o
);

  localparam int unsigned IdxW  = $clog2(MaxVertices);
  localparam int unsigned CntW  = $clog2(MaxVertices + 1);
  localparam int unsigned AddrW = IdxW + 2;
  localparam int unsigned JobW  = 2 * CntW + 2;

  logic                   wr_en;
  logic [AddrW-1:0]       wr_addr;
  logic [2*CoordBits-1:0] wr_data;
  logic                   job_push, job_full, job_pop, job_valid;
  logic [JobW-1:0]        job_in, job_out;

  cpo_front #(
    .MaxVertices (MaxVertices),
    .CoordBits   (CoordBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vtx_i      (vtx_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  cpo_fifo #(
    .Width (JobW),
    .Depth (cpo_pkg::JOB_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .pop_data_o  (job_out),
    .valid_o     (job_valid)
  );

  cpo_back #(
    .MaxVertices (MaxVertices),
    .CoordBits   (CoordBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

[rtl/cpo_front.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap front end
// Accepts vertex requests, writes them to the current bank and posts a test job.
// ----------------------------------------------------------------------------
`default_nettype none

module cpo_front #(
  parameter int unsigned MaxVertices = cpo_pkg::DEF_MAX_VERTICES,
  parameter int unsigned CoordBits   = cpo_pkg::DEF_COORD_BITS,
  localparam int unsigned IdxW  = $clog2(MaxVertices),
  localparam int unsigned CntW  = $clog2(MaxVertices + 1),
  localparam int unsigned AddrW = IdxW + 2,
  localparam int unsigned JobW  = 2 * CntW + 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  cpo_vtx_if.sink                     vtx_i,
  output logic                        wr_en_o,
  output logic [AddrW-1:0]            wr_addr_o,
  output logic [2*CoordBits-1:0]      wr_data_o,
  output logic                        job_push_o,
  output logic [JobW-1:0]             job_o,
  input  wire logic                   job_full_i
);

  typedef struct packed {
    logic            bank;
    logic [CntW-1:0] n0;
    logic [CntW-1:0] n1;
    logic            ovf;
  } job_t;

  logic            bank_q, bank_d;
  logic [CntW-1:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic            ovf_q, ovf_d;
  logic            accept;
  logic [CntW-1:0] cnt_sel;
  logic            full_sel;
  logic [CntW-1:0] n0_now, n1_now;
  logic            ovf_now;
  job_t            job;

  assign vtx_i.ready = !job_full_i;
  assign accept      = vtx_i.valid && !job_full_i;

  assign cnt_sel  = vtx_i.polygon_select ? cnt1_q : cnt0_q;
  assign full_sel = (cnt_sel == CntW'(MaxVertices));

  assign wr_en_o   = accept && vtx_i.vertex_valid && !full_sel;
  assign wr_addr_o = {bank_q, vtx_i.polygon_select, cnt_sel[IdxW-1:0]};
  assign wr_data_o = {vtx_i.vertex_x, vtx_i.vertex_y};

  // Counts and overflow as they stand once this request's vertex is stored.
  always_comb begin
    n0_now  = cnt0_q;
    n1_now  = cnt1_q;
    ovf_now = ovf_q;
    if (accept && vtx_i.vertex_valid) begin
      if (full_sel) begin
        ovf_now = 1'b1;
      end else if (vtx_i.polygon_select) begin
        n1_now = cnt1_q + CntW'(1);
      end else begin
        n0_now = cnt0_q + CntW'(1);
      end
    end
  end

  assign job_push_o = accept && vtx_i.end_of_polygon && vtx_i.polygon_select;
  assign job.bank   = bank_q;
  assign job.n0     = n0_now;
  assign job.n1     = n1_now;
  assign job.ovf    = ovf_now;
  assign job_o      = job;

  always_comb begin
    bank_d = bank_q;
    cnt0_d = n0_now;
    cnt1_d = n1_now;
    ovf_d  = ovf_now;
    if (job_push_o) begin
      bank_d = !bank_q;
      cnt0_d = '0;
      cnt1_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      cnt0_q <= '0;
      cnt1_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      bank_q <= bank_d;
      cnt0_q <= cnt0_d;
      cnt1_q <= cnt1_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cpo_fifo.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap job queue
// Small first-in first-out queue of test jobs between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cpo_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = cpo_pkg::JOB_DEPTH,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      pop_data_o,
  output logic                  valid_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/cpo_back.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap back end
// Holds the vertex banks and runs the separating-axis test for each job.
// ----------------------------------------------------------------------------
`default_nettype none

module cpo_back #(
  parameter int unsigned MaxVertices = cpo_pkg::DEF_MAX_VERTICES,
  parameter int unsigned CoordBits   = cpo_pkg::DEF_COORD_BITS,
  localparam int unsigned IdxW  = $clog2(MaxVertices),
  localparam int unsigned CntW  = $clog2(MaxVertices + 1),
  localparam int unsigned AddrW = IdxW + 2,
  localparam int unsigned JobW  = 2 * CntW + 2,
  localparam int unsigned AxisW = CoordBits + 1,
  localparam int unsigned ProdW = 2 * CoordBits + 1,
  localparam int unsigned ProjW = 2 * CoordBits + 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_en_i,
  input  wire logic [AddrW-1:0]       wr_addr_i,
  input  wire logic [2*CoordBits-1:0] wr_data_i,
  input  wire logic                   job_valid_i,
  input  wire logic [JobW-1:0]        job_i,
  output logic                        job_pop_o,
  cpo_res_if.source                   res_o
);

  typedef struct packed {
    logic            bank;
    logic [CntW-1:0] n0;
    logic [CntW-1:0] n1;
    logic            ovf;
  } job_t;

  logic [2*CoordBits-1:0] mem_q [2**AddrW];
  logic [2*CoordBits-1:0] rdata_q;
  logic [AddrW-1:0]       rd_addr;

  cpo_pkg::state_e state_q, state_d;
  job_t            job;

  logic            edge_poly_q;
  logic [IdxW-1:0] edge_idx_q;
  logic            proj_poly_q;
  logic [IdxW-1:0] proj_idx_q;

  logic signed [CoordBits-1:0] vi_x_q, vi_y_q;
  logic signed [CoordBits-1:0] rd_x, rd_y;
  logic signed [AxisW-1:0]     nx_q, ny_q;
  logic signed [ProdW-1:0]     px_q, py_q, px_w, py_w;
  logic signed [ProjW-1:0]     sum_q;
  logic signed [ProjW-1:0]     mn0_q, mx0_q, mn1_q, mx1_q;

  cpo_pkg::pipe_tag_t t1_q, t2_q, t3_q, t1_d;

  logic            hit_q;
  logic            res_valid_q, res_collide_q, res_ovf_q;

  logic [CntW-1:0] n_edge, edge_nxt, n_proj, proj_nxt;
  logic            edge_last, proj_last;
  logic [IdxW-1:0] edge_j;
  logic            trivial, pipe_empty, sep, can_load, test_end;

  assign job = job_t'(job_i);

  // Edge and projection walk positions.
  assign n_edge    = edge_poly_q ? job.n1 : job.n0;
  assign edge_nxt  = CntW'(edge_idx_q) + CntW'(1);
  assign edge_last = (edge_nxt == n_edge);
  assign edge_j    = edge_last ? '0 : edge_nxt[IdxW-1:0];
  assign n_proj    = proj_poly_q ? job.n1 : job.n0;
  assign proj_nxt  = CntW'(proj_idx_q) + CntW'(1);
  assign proj_last = (proj_nxt == n_proj);

  assign trivial    = job.ovf || (job.n0 == '0) || (job.n1 == '0);
  assign pipe_empty = !t1_q.vld && !t2_q.vld && !t3_q.vld;
  // Touching intervals count as separated.
  assign sep        = !(mn1_q < mx0_q) || !(mn0_q < mx1_q);
  assign test_end   = sep || (edge_last && edge_poly_q);
  assign can_load   = !res_valid_q || res_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpo_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          state_d = trivial ? cpo_pkg::ST_EMIT : cpo_pkg::ST_EDGE_A;
        end
      end
      cpo_pkg::ST_EDGE_A: state_d = cpo_pkg::ST_EDGE_B;
      cpo_pkg::ST_EDGE_B: state_d = cpo_pkg::ST_AXIS;
      cpo_pkg::ST_AXIS:   state_d = cpo_pkg::ST_PROJ;
      cpo_pkg::ST_PROJ: begin
        if (proj_poly_q && proj_last) begin
          state_d = cpo_pkg::ST_DRAIN;
        end
      end
      cpo_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = test_end ? cpo_pkg::ST_EMIT : cpo_pkg::ST_EDGE_A;
        end
      end
      cpo_pkg::ST_EMIT: begin
        if (can_load) begin
          state_d = cpo_pkg::ST_IDLE;
        end
      end
      default: state_d = cpo_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    rd_addr   = '0;
    t1_d      = '0;
    job_pop_o = 1'b0;
    case (state_q)
      cpo_pkg::ST_EDGE_A: rd_addr = {job.bank, edge_poly_q, edge_idx_q};
      cpo_pkg::ST_EDGE_B: rd_addr = {job.bank, edge_poly_q, edge_j};
      cpo_pkg::ST_PROJ: begin
        rd_addr    = {job.bank, proj_poly_q, proj_idx_q};
        t1_d.vld   = 1'b1;
        t1_d.poly  = proj_poly_q;
        t1_d.first = (proj_idx_q == '0);
      end
      cpo_pkg::ST_EMIT: job_pop_o = can_load;
      default: rd_addr = '0;
    endcase
  end

  // Vertex banks: one write port from the front end, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign rd_x = rdata_q[2*CoordBits-1:CoordBits];
  assign rd_y = rdata_q[CoordBits-1:0];
  assign px_w = ProdW'(nx_q) * ProdW'(rd_x);
  assign py_w = ProdW'(ny_q) * ProdW'(rd_y);

  // Projection pipeline: read, multiply, add, then interval update.
  always_ff @(posedge clk_i) begin
    if (state_q == cpo_pkg::ST_EDGE_B) begin
      vi_x_q <= rd_x;
      vi_y_q <= rd_y;
    end
    if (state_q == cpo_pkg::ST_AXIS) begin
      nx_q <= AxisW'(rd_y) - AxisW'(vi_y_q);
      ny_q <= AxisW'(vi_x_q) - AxisW'(rd_x);
    end
    px_q  <= px_w;
    py_q  <= py_w;
    sum_q <= ProjW'(px_q) + ProjW'(py_q);
    if (t3_q.vld && !t3_q.poly) begin
      if (t3_q.first || sum_q < mn0_q) mn0_q <= sum_q;
      if (t3_q.first || mx0_q < sum_q) mx0_q <= sum_q;
    end
    if (t3_q.vld && t3_q.poly) begin
      if (t3_q.first || sum_q < mn1_q) mn1_q <= sum_q;
      if (t3_q.first || mx1_q < sum_q) mx1_q <= sum_q;
    end
    if (state_q == cpo_pkg::ST_IDLE) begin
      hit_q <= 1'b0;
    end else if (state_q == cpo_pkg::ST_DRAIN && pipe_empty) begin
      hit_q <= !sep;
    end
    if (state_q == cpo_pkg::ST_EMIT && can_load) begin
      res_collide_q <= hit_q;
      res_ovf_q     <= job.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpo_pkg::ST_IDLE;
      t1_q        <= '0;
      t2_q        <= '0;
      t3_q        <= '0;
      res_valid_q <= 1'b0;
      edge_poly_q <= 1'b0;
      edge_idx_q  <= '0;
      proj_poly_q <= 1'b0;
      proj_idx_q  <= '0;
    end else begin
      state_q <= state_d;
      t1_q    <= t1_d;
      t2_q    <= t1_q;
      t3_q    <= t2_q;
      if (state_q == cpo_pkg::ST_EMIT && can_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (state_q == cpo_pkg::ST_IDLE) begin
        edge_poly_q <= 1'b0;
        edge_idx_q  <= '0;
      end else if (state_q == cpo_pkg::ST_DRAIN && pipe_empty && !test_end) begin
        if (edge_last) begin
          edge_poly_q <= 1'b1;
          edge_idx_q  <= '0;
        end else begin
          edge_idx_q <= edge_nxt[IdxW-1:0];
        end
      end
      if (state_q == cpo_pkg::ST_AXIS) begin
        proj_poly_q <= 1'b0;
        proj_idx_q  <= '0;
      end else if (state_q == cpo_pkg::ST_PROJ) begin
        if (proj_last) begin
          proj_poly_q <= 1'b1;
          proj_idx_q  <= '0;
        end else begin
          proj_idx_q <= proj_nxt[IdxW-1:0];
        end
      end
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.collide  = res_collide_q;
  assign res_o.overflow = res_ovf_q;

endmodule

`default_nettype wire

[rtl/cpo_checker.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap checker
// Port-level assertions on the overlap test, attached to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpo_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_sel_i,
  input wire logic in_end_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_collide_i,
  input wire logic out_overflow_i
);

  // Closed pairs whose result has not yet been taken.
  logic [2:0] pend_q;
  logic       pair_in, res_out;

  assign pair_in = in_valid_i && in_ready_i && in_sel_i && in_end_i;
  assign res_out = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (pair_in && !res_out) begin
      pend_q <= pend_q + 3'd1;
    end else if (res_out && !pair_in) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({out_collide_i, out_overflow_i}))
    else $error("result changed while stalled");

  a_res_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result without a closed polygon pair");

  a_ovf_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_overflow_i |-> !out_collide_i)
    else $error("collision reported together with overflow");

  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> pend_q >= 3'd2)
    else $error("input stalled with a free vertex bank");

endmodule

bind convex_polygon_overlap_test cpo_checker u_cpo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (vtx_i.valid),
  .in_ready_i     (vtx_i.ready),
  .in_sel_i       (vtx_i.polygon_select),
  .in_end_i       (vtx_i.end_of_polygon),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_collide_i  (res_o.collide),
  .out_overflow_i (res_o.overflow)
);

`default_nettype wire

[tb/cpo_overlap_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap scoreboard
// Request and result types and a scoreboard that predicts the overlap verdict.
// The scoreboard keeps its own copy of both vertex stores. Each test uses
// exact 64-bit projections on every edge normal of both polygons.
// ----------------------------------------------------------------------------
package cpo_overlap_scoreboard_pkg;

  localparam int unsigned MAX_VERTS = cpo_pkg::DEF_MAX_VERTICES;
  localparam int unsigned COORD_W   = cpo_pkg::DEF_COORD_BITS;

  localparam bit POLY_FIRST  = 1'b0;
  localparam bit POLY_SECOND = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   polygon_select;
    logic   vertex_valid;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   end_of_polygon;
  } vertex_req_t;

  typedef struct packed {
    logic collide;
    logic overflow;
  } overlap_res_t;

  class overlap_scoreboard;
    longint       vx [2][MAX_VERTS];
    longint       vy [2][MAX_VERTS];
    int unsigned  vcount [2];
    bit           overflow_seen;
    overlap_res_t verdict_q [$];
    int unsigned  errors;

    function new();
      clear_pair();
      errors = 0;
    endfunction

    function void clear_pair();
      vcount[0]     = 0;
      vcount[1]     = 0;
      overflow_seen = 1'b0;
    endfunction

    // Minimum and maximum of the projections of polygon s on (nx, ny).
    function void project_span(input longint nx, input longint ny, input int unsigned s,
                               output longint lo, output longint hi);
      longint q;
      lo = nx * vx[s][0] + ny * vy[s][0];
      hi = lo;
      for (int unsigned i = 1; i < vcount[s]; i++) begin
        q = nx * vx[s][i] + ny * vy[s][i];
        if (q < lo) lo = q;
        if (q > hi) hi = q;
      end
    endfunction

    // True if some edge normal of polygon s separates the pair. Touching
    // intervals count as separated, which also covers zero-length edges.
    function bit edges_separate(input int unsigned s);
      int unsigned j;
      longint      ex, ey, lo0, hi0, lo1, hi1;
      for (int unsigned i = 0; i < vcount[s]; i++) begin
        j  = (i + 1 == vcount[s]) ? 0 : i + 1;
        ex = vx[s][j] - vx[s][i];
        ey = vy[s][j] - vy[s][i];
        project_span(ey, -ex, 0, lo0, hi0);
        project_span(ey, -ex, 1, lo1, hi1);
        if (lo1 >= hi0 || lo0 >= hi1) return 1'b1;
      end
      return 1'b0;
    endfunction

    function overlap_res_t predict_overlap();
      overlap_res_t v;
      v.overflow = overflow_seen;
      if (overflow_seen || vcount[0] == 0 || vcount[1] == 0) begin
        v.collide = 1'b0;
      end else begin
        v.collide = !edges_separate(0) && !edges_separate(1);
      end
      return v;
    endfunction

    function void note_request(input vertex_req_t r);
      int unsigned s;
      s = r.polygon_select;
      if (r.vertex_valid) begin
        if (vcount[s] >= MAX_VERTS) begin
          overflow_seen = 1'b1;
        end else begin
          vx[s][vcount[s]] = longint'($signed(r.vertex_x));
          vy[s][vcount[s]] = longint'($signed(r.vertex_y));
          vcount[s]++;
        end
      end
      if (r.end_of_polygon && r.polygon_select == POLY_SECOND) begin
        verdict_q.insert(verdict_q.size(), predict_overlap());
        clear_pair();
      end
    endfunction

    function void check_result(input overlap_res_t got);
      overlap_res_t want;
      if (verdict_q.size() == 0) begin
        $error("result with no pending test: collide %0b overflow %0b",
               got.collide, got.overflow);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (got.collide !== want.collide) begin
        $error("collide: expected %0b, actual %0b", want.collide, got.collide);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

endpackage

[tb/tb_convex_polygon_overlap_test.sv]
// ----------------------------------------------------------------------------
// Convex polygon overlap test bench
// Feeds directed and random polygon pairs, with random idling on both
// channels, and compares every verdict with the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_convex_polygon_overlap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpo_overlap_scoreboard_pkg::*;

  localparam int unsigned TOTAL_REQUESTS = 1050;
  localparam int unsigned DRAIN_CYCLES   = 2000;
  localparam real         TWO_PI         = 6.283185307179586;

  logic clk_i;
  logic rst_ni;

  cpo_vtx_if vtx ();
  cpo_res_if res ();

  convex_polygon_overlap_test DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .res_o  (res)
  );

  overlap_scoreboard sb = new();

  int unsigned src_idle_pct = 10;
  int unsigned snk_idle_pct = 50;
  int unsigned sent_count   = 0;
  vertex_req_t first_q [$];
  vertex_req_t second_q [$];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    res.ready = rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res.valid && res.ready) begin
      sb.check_result(overlap_res_t'({res.collide, res.overflow}));
    end
  end

  function automatic vertex_req_t make_req(input bit sel, input bit has_vertex,
                                           input int x, input int y, input bit eop);
    vertex_req_t r;
    r.polygon_select = sel;
    r.vertex_valid   = has_vertex;
    r.vertex_x       = coord_t'(x);
    r.vertex_y       = coord_t'(y);
    r.end_of_polygon = eop;
    return r;
  endfunction

  function automatic real unit_rand();
    return $urandom_range(0, 65535) / 65535.0;
  endfunction

  function automatic int to_coord(input real v);
    if (v > 32767.0) return 32767;
    if (v < -32768.0) return -32768;
    return $rtoi(v);
  endfunction

  function automatic int unsigned pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(3, 6);
    if (p < 95) return $urandom_range(1, MAX_VERTS);
    return MAX_VERTS;
  endfunction

  function automatic real pick_radius();
    return real'(1 << $urandom_range(3, 14)) * (0.5 + unit_rand());
  endfunction

  // Entered just after a falling edge; returns just after the falling edge
  // that follows acceptance, leaving valid high for the next request.
  task automatic send_request(input vertex_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      vtx.valid = 1'b0;
      @(negedge clk_i);
    end
    vtx.valid          = 1'b1;
    vtx.polygon_select = r.polygon_select;
    vtx.vertex_valid   = r.vertex_valid;
    vtx.vertex_x       = r.vertex_x;
    vtx.vertex_y       = r.vertex_y;
    vtx.end_of_polygon = r.end_of_polygon;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    sb.note_request(r);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic push_vertex(input vertex_req_t r);
    if (r.polygon_select == POLY_SECOND) second_q.insert(second_q.size(), r);
    else first_q.insert(first_q.size(), r);
  endtask

  // Vertices on a stretched circle in angular order, so the outline is convex
  // apart from rounding and clamping. Now and then one vertex is repeated.
  task automatic add_polygon(input bit sel, input int unsigned n, input real cx,
                             input real cy, input real rad);
    real         base, stretch, a;
    bit          cw;
    int unsigned dup;
    vertex_req_t r;
    base    = unit_rand() * TWO_PI;
    stretch = 0.4 + unit_rand() * 1.2;
    cw      = $urandom_range(1);
    dup     = ($urandom_range(9) == 0 && n >= 2) ? $urandom_range(n - 1) : n;
    for (int unsigned k = 0; k < n; k++) begin
      a = base + (k + 0.5 * unit_rand()) * TWO_PI / n;
      if (cw) a = -a;
      r = make_req(sel, 1'b1, to_coord(cx + rad * stretch * $cos(a)),
                   to_coord(cy + rad * $sin(a)), 1'b0);
      push_vertex(r);
      if (k == dup) push_vertex(r);
    end
  endtask

  task automatic add_scatter(input bit sel, input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      push_vertex(make_req(sel, 1'b1, $urandom, $urandom, 1'b0));
    end
  endtask

  task automatic send_random_pair();
    int unsigned kind, n_first, n_second;
    real         cx, cy, r1, r2, ang, gap;
    bit          interleave;
    vertex_req_t closing;
    first_q.delete();
    second_q.delete();
    kind     = $urandom_range(99);
    n_first  = pick_size();
    n_second = pick_size();
    cx       = unit_rand() * 48000.0 - 24000.0;
    cy       = unit_rand() * 48000.0 - 24000.0;
    r1       = pick_radius();
    r2       = pick_radius();
    ang      = unit_rand() * TWO_PI;
    gap      = unit_rand() * 1.3 * (r1 + r2);
    if (kind < 80) begin
      if (kind >= 70) begin
        if ($urandom_range(1)) n_first = $urandom_range(MAX_VERTS + 1, MAX_VERTS + 4);
        else n_second = $urandom_range(MAX_VERTS + 1, MAX_VERTS + 4);
      end
      add_polygon(POLY_FIRST, n_first, cx, cy, r1);
      add_polygon(POLY_SECOND, n_second, cx + gap * $cos(ang), cy + gap * $sin(ang), r2);
    end else if (kind < 88) begin
      // One polygon left empty.
      if ($urandom_range(1)) add_polygon(POLY_FIRST, n_first, cx, cy, r1);
      else add_polygon(POLY_SECOND, n_second, cx, cy, r2);
    end else begin
      add_scatter(POLY_FIRST, $urandom_range(1, 8));
      add_scatter(POLY_SECOND, $urandom_range(1, 8));
    end

    // The end mark of the first polygon is optional and may come bare.
    if (first_q.size() != 0 && $urandom_range(99) < 60) begin
      first_q[first_q.size() - 1].end_of_polygon = 1'b1;
    end else if ($urandom_range(99) < 70) begin
      first_q.insert(first_q.size(), make_req(POLY_FIRST, 1'b0, $urandom, $urandom, 1'b1));
    end
    if (second_q.size() != 0 && $urandom_range(99) < 60) begin
      second_q[second_q.size() - 1].end_of_polygon = 1'b1;
    end else begin
      second_q.insert(second_q.size(), make_req(POLY_SECOND, 1'b0, $urandom, $urandom, 1'b1));
    end

    interleave = ($urandom_range(99) < 30);
    closing    = second_q.pop_back();
    while (first_q.size() + second_q.size() != 0) begin
      if ($urandom_range(99) < 3) begin
        send_request(make_req($urandom_range(1), 1'b0, $urandom, $urandom, 1'b0));
      end
      if (second_q.size() == 0 || (first_q.size() != 0 && (!interleave || $urandom_range(1))))
        send_request(first_q.pop_front());
      else
        send_request(second_q.pop_front());
    end
    send_request(closing);
  endtask

  task automatic send_directed();
    // Both polygons empty: only the end mark of the second.
    send_request(make_req(POLY_SECOND, 1'b0, 0, 0, 1'b1));

    // Square and triangle overlapping; the first closed by a bare end mark.
    send_request(make_req(POLY_FIRST, 1'b1, 0, 0, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 256, 0, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 256, 256, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 0, 256, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b0, 0, 0, 1'b1));
    send_request(make_req(POLY_SECOND, 1'b1, 128, 128, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, 512, 128, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, 128, 512, 1'b1));

    // Squares sharing an edge: the intervals only touch.
    send_request(make_req(POLY_FIRST, 1'b1, 0, 0, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, 256, 0, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 256, 0, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, 512, 0, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 256, 256, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 0, 256, 1'b1));
    send_request(make_req(POLY_SECOND, 1'b1, 512, 256, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, 256, 256, 1'b1));

    // Full-range triangle around a tiny one.
    send_request(make_req(POLY_FIRST, 1'b1, -32768, -32768, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 32767, -32768, 1'b0));
    send_request(make_req(POLY_FIRST, 1'b1, 0, 32767, 1'b1));
    send_request(make_req(POLY_SECOND, 1'b1, -1, -1, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, 1, -1, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, 0, 1, 1'b1));

    // A single vertex against a repeated one: every edge has zero length.
    send_request(make_req(POLY_FIRST, 1'b1, 32767, 32767, 1'b1));
    send_request(make_req(POLY_SECOND, 1'b1, -32768, -32768, 1'b0));
    send_request(make_req(POLY_SECOND, 1'b1, -32768, -32768, 1'b1));

    // First polygon empty.
    send_request(make_req(POLY_SECOND, 1'b1, 100, -100, 1'b1));
  endtask

  initial begin
    rst_ni             = 1'b0;
    res.ready          = 1'b0;
    vtx.valid          = 1'b0;
    vtx.polygon_select = 1'b0;
    vtx.vertex_valid   = 1'b0;
    vtx.vertex_x       = '0;
    vtx.vertex_y       = '0;
    vtx.end_of_polygon = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();
    while (sent_count < TOTAL_REQUESTS) begin
      if (sent_count < TOTAL_REQUESTS / 3) begin
        src_idle_pct = 10;
        snk_idle_pct = 50;
      end else if (sent_count < 2 * TOTAL_REQUESTS / 3) begin
        src_idle_pct = 50;
        snk_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_random_pair();
    end
    vtx.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
